// ===== src/adaptive_lif_neuron_step_defines.svh =====
// Assertion macros shared by the adaptive LIF neuron RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef ADAPTIVE_LIF_NEURON_STEP_DEFINES_SVH
`define ADAPTIVE_LIF_NEURON_STEP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk and disabled during reset.
`define ALIF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alif assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define ALIF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alif assertion failed");

`else

`define ALIF_ASSERT_IMP(label, ante, cons)
`define ALIF_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== src/alif_pkg.sv =====
// Types, register indexes, reset values and the saturation helper of the
// adaptive LIF neuron. No dependencies.
`default_nettype none

package alif_pkg;

  localparam int CFG_W          = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int INTERVAL_OUT_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVE_MEAN     = 3'd0,
    REG_TIME_STEP      = 3'd1,
    REG_ADAPT_DECAY    = 3'd2,
    REG_ADAPT_JUMP     = 3'd3,
    REG_NOISE_GAIN     = 3'd4,
    REG_FIRE_THRESHOLD = 3'd5
  } cfg_reg_t;

  localparam logic [31:0] RST_DRIVE_MEAN     = 32'd33554432;
  localparam logic [24:0] RST_TIME_STEP      = 25'd3355;
  localparam logic [24:0] RST_ADAPT_DECAY    = 25'd1678;
  localparam logic [31:0] RST_ADAPT_JUMP     = 32'd16777216;
  localparam logic [30:0] RST_NOISE_GAIN     = 31'd0;
  localparam logic [31:0] RST_FIRE_THRESHOLD = 32'd16777216;

  typedef struct packed {
    logic [31:0] drive_mean;
    logic [24:0] time_step;
    logic [24:0] adapt_decay;
    logic [31:0] adapt_jump;
    logic [30:0] noise_gain;
    logic [31:0] fire_threshold;
  } alif_cfg_t;

  typedef struct packed {
    logic                      spiked;
    logic [INTERVAL_OUT_W-1:0] interval_ticks;
    logic [31:0]               membrane;
    logic [31:0]               adaptation;
  } alif_res_t;

  // Clamp a widened sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [31:0] r;
    if (x > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/alif_cfg.sv =====
// Configuration register file of the adaptive LIF neuron.
// Depends on alif_pkg for register indexes, reset values and alif_cfg_t.
`default_nettype none

module alif_cfg
  import alif_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output alif_cfg_t                 cfg
);

  alif_cfg_t cfg_r;
  alif_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DRIVE_MEAN:     cfg_nxt.drive_mean     = cfg_wdata;
        REG_TIME_STEP:      cfg_nxt.time_step      = cfg_wdata[24:0];
        REG_ADAPT_DECAY:    cfg_nxt.adapt_decay    = cfg_wdata[24:0];
        REG_ADAPT_JUMP:     cfg_nxt.adapt_jump     = cfg_wdata;
        REG_NOISE_GAIN:     cfg_nxt.noise_gain     = cfg_wdata[30:0];
        REG_FIRE_THRESHOLD: cfg_nxt.fire_threshold = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_mean     <= RST_DRIVE_MEAN;
      cfg_r.time_step      <= RST_TIME_STEP;
      cfg_r.adapt_decay    <= RST_ADAPT_DECAY;
      cfg_r.adapt_jump     <= RST_ADAPT_JUMP;
      cfg_r.noise_gain     <= RST_NOISE_GAIN;
      cfg_r.fire_threshold <= RST_FIRE_THRESHOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== src/alif_step.sv =====
// Neuron state (membrane, adaptation, tick counter) and the one-tick
// Euler-Maruyama update. Depends on alif_pkg for alif_cfg_t, alif_res_t, sat32.
`default_nettype none

module alif_step
  import alif_pkg::*;
#(
  parameter int INTERVAL_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire alif_cfg_t   cfg,
  input  wire logic        step_en,
  input  wire logic [15:0] noise,
  output alif_res_t        res
);

  logic signed [31:0]      membrane_r;
  logic signed [31:0]      membrane_nxt;
  logic signed [31:0]      adaptation_r;
  logic signed [31:0]      adaptation_nxt;
  logic [INTERVAL_BITS-1:0] ticks_r;
  logic [INTERVAL_BITS-1:0] ticks_nxt;
  logic [INTERVAL_BITS-1:0] ticks_inc;

  logic signed [33:0] diff;
  logic signed [59:0] prod_drift;
  logic signed [59:0] rnd_drift;
  logic signed [35:0] drift;
  logic signed [47:0] prod_kick;
  logic signed [47:0] rnd_kick;
  logic signed [35:0] kick;
  logic signed [39:0] m_sum;
  logic signed [31:0] m_sat;
  logic signed [57:0] prod_leak;
  logic signed [57:0] rnd_leak;
  logic signed [33:0] leak;
  logic signed [39:0] a_sum;
  logic signed [31:0] a_sat;
  logic signed [31:0] a_jump;
  logic               fire;
  logic [INTERVAL_OUT_W-1:0] interval_sat;

  always_comb begin
    // Drift uses the adaptation value from before this tick.
    diff = 34'($signed(cfg.drive_mean)) - 34'(membrane_r) - 34'(adaptation_r);
    prod_drift = 60'(diff) * 60'($signed({1'b0, cfg.time_step}));
    rnd_drift  = prod_drift + (60'sd1 <<< 23);
    drift      = rnd_drift[59:24];

    prod_kick = 48'($signed({1'b0, cfg.noise_gain})) * 48'($signed(noise));
    rnd_kick  = prod_kick + (48'sd1 <<< 11);
    kick      = rnd_kick[47:12];

    m_sum = 40'(membrane_r) + 40'(drift) + 40'(kick);
    m_sat = sat32(m_sum);

    prod_leak = 58'(adaptation_r) * 58'($signed({1'b0, cfg.adapt_decay}));
    rnd_leak  = prod_leak + (58'sd1 <<< 23);
    leak      = rnd_leak[57:24];
    a_sum     = 40'(adaptation_r) - 40'(leak);
    a_sat     = sat32(a_sum);

    a_jump = sat32(40'(a_sat) + 40'($signed(cfg.adapt_jump)));
    fire   = m_sat > $signed(cfg.fire_threshold);

    ticks_inc = (&ticks_r) ? ticks_r : ticks_r + INTERVAL_BITS'(1);
  end

  generate
    if (INTERVAL_BITS > INTERVAL_OUT_W) begin : g_wide_cnt
      assign interval_sat = (|ticks_inc[INTERVAL_BITS-1:INTERVAL_OUT_W]) ?
                            '1 : ticks_inc[INTERVAL_OUT_W-1:0];
    end else begin : g_narrow_cnt
      assign interval_sat = INTERVAL_OUT_W'(ticks_inc);
    end
  endgenerate

  always_comb begin
    res.spiked         = fire;
    res.interval_ticks = fire ? interval_sat : '0;
    res.membrane       = fire ? 32'd0 : m_sat;
    res.adaptation     = fire ? a_jump : a_sat;
    membrane_nxt       = fire ? 32'sd0 : m_sat;
    adaptation_nxt     = fire ? a_jump : a_sat;
    ticks_nxt          = fire ? '0 : ticks_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      membrane_r   <= '0;
      adaptation_r <= '0;
      ticks_r      <= '0;
    end else if (step_en) begin
      membrane_r   <= membrane_nxt;
      adaptation_r <= adaptation_nxt;
      ticks_r      <= ticks_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/adaptive_lif_neuron_step.sv =====
// Top level of the adaptive LIF neuron: config registers, input register, step logic, result register.
// Depends on alif_pkg, alif_cfg, alif_step and adaptive_lif_neuron_step_defines.svh.
//
//   Channel  Ports                                   Handshake
//   input    in_noise_sample                         in_valid / in_ready
//   result   out_spiked, out_interval_ticks,         out_valid / out_ready
//            out_membrane_out, out_adaptation_out
//   config   cfg_index, cfg_wdata                    cfg_we, no wait
//
// One tick per cycle sustained while out_ready stays high; an accepted request waits in the
// input register, and its result is loaded into the result register when the neuron steps.
// The tick rate is set by the combinational state update in alif_step (three
// multipliers, the rounding adds and the saturating compare).
// Synchronous reset clears the neuron state, the tick counter and both valids,
// and loads the register defaults.
// A stalled result holds its register; the input register still takes one
// request, then in_ready drops until the result is taken.
`default_nettype none

`include "adaptive_lif_neuron_step_defines.svh"

module adaptive_lif_neuron_step
  import alif_pkg::*;
#(
  parameter int INTERVAL_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [15:0]        in_noise_sample,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_spiked,
  output logic [INTERVAL_OUT_W-1:0]      out_interval_ticks,
  output logic signed [31:0]             out_membrane_out,
  output logic signed [31:0]             out_adaptation_out
);

  alif_cfg_t   cfg;
  alif_res_t   res;
  alif_res_t   res_r;

  logic        in_valid_r;
  logic        in_valid_nxt;
  logic [15:0] noise_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        in_take;
  logic        step_en;

  alif_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  alif_step #(
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step_en (step_en),
    .noise   (noise_r),
    .res     (res)
  );

  // A buffered request steps the neuron whenever the result register is empty or being taken.
  assign step_en  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step_en;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_valid_nxt = in_take ? 1'b1 : (step_en ? 1'b0 : in_valid_r);
    out_valid_nxt = step_en ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      noise_r <= in_noise_sample;
    end
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_spiked         = res_r.spiked;
  assign out_interval_ticks = res_r.interval_ticks;
  assign out_membrane_out   = res_r.membrane;
  assign out_adaptation_out = res_r.adaptation;

  `ALIF_ASSERT_IMP(a_spike_resets_membrane, out_valid && out_spiked, out_membrane_out == 32'd0)
  `ALIF_ASSERT_IMP(a_quiet_no_interval, out_valid && !out_spiked, out_interval_ticks == '0)
  `ALIF_ASSERT_IMP(a_spike_interval_nonzero, out_valid && out_spiked, out_interval_ticks != '0)
  `ALIF_ASSERT_IMP(a_stall_only_when_full, !in_ready, in_valid_r && out_valid_r && !out_ready)
  `ALIF_ASSERT_NXT(a_step_gives_result, step_en, out_valid)

endmodule

`default_nettype wire
